// ----- hw/rtl/dlir_pkg.sv -----
// Package for the display linear interpolation resampler.
// Holds widths, limits, register indexes and the control/status structs.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dlir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 25;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = 24;
    localparam int GAIN_W      = 16;
    localparam int WIDTH_W     = 13;
    localparam int COL_W       = 12;
    localparam int POINT_W     = 24;
    localparam int BLEND_W     = 34;
    localparam int PROD_W      = 51;
    localparam int ROUND_SHIFT = 28;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int MAX_COLUMNS           = 4096;
    localparam int MAX_POINTS_PER_SAMPLE = 16;
    localparam int CNT_W                 = $clog2(MAX_POINTS_PER_SAMPLE + 1);

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(32'h0001_0000);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_COLUMNS);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = WIDTH_W'(1);
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_POINTS_PER_SAMPLE);
    localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(MAX_POINTS_PER_SAMPLE - 1);

    localparam logic [POINT_W-1:0] PT_MAX = 24'h7F_FFFF;
    localparam logic [POINT_W-1:0] PT_MIN = 24'h80_0000;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'h01_0000;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'h1000;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd2;

    typedef struct packed {
        logic accept;
        logic point;
        logic mul1;
        logic mul2;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic primed;
        logic point_go;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dlir_ctrl.sv -----
// Controller state machine of the display linear interpolation resampler.
// Sequences accept, point set-up, two multiply steps and the output load.
// Depends on dlir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlir_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_restart,
    output logic                  in_ready,
    input  dlir_pkg::status_t     status,
    output dlir_pkg::cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POINT = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!in_restart && status.primed)
                    begin
                        state_next = ST_POINT;
                    end
                end
            end
            ST_POINT:
            begin
                if (status.point_go)
                begin
                    cmd.point  = 1'b1;
                    state_next = ST_MUL1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_POINT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dlir_dp.sv -----
// Datapath of the display linear interpolation resampler: configuration
// registers, phase and column state, blend and gain multipliers, output register.
// Depends on dlir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlir_dp
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [dlir_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [dlir_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [dlir_pkg::SAMPLE_W-1:0]      in_sample,
    input  wire logic                               in_restart,
    input  dlir_pkg::cmd_t                          cmd,
    output dlir_pkg::status_t                       status,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [dlir_pkg::COL_W-1:0]              out_column,
    output logic [dlir_pkg::POINT_W-1:0]            out_point,
    output logic                                    out_last
);

    logic [dlir_pkg::STEP_W-1:0]   step_reg;
    logic [dlir_pkg::GAIN_W-1:0]   gain_reg;
    logic [dlir_pkg::WIDTH_W-1:0]  width_reg;

    logic [dlir_pkg::SAMPLE_W-1:0] prev_reg;
    logic [dlir_pkg::SAMPLE_W-1:0] cur_reg;
    logic                          primed_reg;
    logic [dlir_pkg::PHASE_W-1:0]  phase_reg;
    logic [dlir_pkg::COL_W-1:0]    col_reg;
    logic [dlir_pkg::CNT_W-1:0]    cnt_reg;

    logic [dlir_pkg::FRAC_W-1:0]   frac_reg;
    logic [dlir_pkg::COL_W-1:0]    pcol_reg;
    logic                          plast_reg;
    logic signed [dlir_pkg::BLEND_W-1:0] blend_reg;
    logic signed [dlir_pkg::PROD_W-1:0]  prod_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [dlir_pkg::COL_W-1:0]    out_col_reg;
    logic [dlir_pkg::POINT_W-1:0]  out_pt_reg;
    logic                          out_last_reg;

    logic [dlir_pkg::WIDTH_W-1:0]  width_eff;
    logic [dlir_pkg::COL_W-1:0]    col_eff;
    logic [dlir_pkg::WIDTH_W-1:0]  col_inc;
    logic [dlir_pkg::COL_W-1:0]    col_nxt;
    logic [dlir_pkg::PHASE_W-1:0]  phase_add;
    logic [dlir_pkg::PHASE_W-1:0]  phase_fin;
    logic                          pt_last;

    logic signed [dlir_pkg::SAMPLE_W:0]  diff;
    logic signed [dlir_pkg::BLEND_W-1:0] diff_prod;
    logic signed [dlir_pkg::BLEND_W-1:0] prev_scaled;
    logic signed [dlir_pkg::BLEND_W-1:0] blend_sum;
    logic signed [dlir_pkg::PROD_W-1:0]  gain_prod;
    logic signed [dlir_pkg::PROD_W-1:0]  rounded;
    logic signed [dlir_pkg::PROD_W-1:0]  quot;
    logic                                ovf;
    logic [dlir_pkg::POINT_W-1:0]        pt_sat;

    // Effective width, column wrap and phase bookkeeping for one point.
    always_comb
    begin
        if (width_reg == '0)
        begin
            width_eff = dlir_pkg::WIDTH_MIN;
        end
        else if (width_reg > dlir_pkg::WIDTH_MAX)
        begin
            width_eff = dlir_pkg::WIDTH_MAX;
        end
        else
        begin
            width_eff = width_reg;
        end
        col_eff   = ({1'b0, col_reg} >= width_eff) ? '0 : col_reg;
        col_inc   = {1'b0, col_eff} + dlir_pkg::WIDTH_W'(1);
        col_nxt   = (col_inc >= width_eff) ? '0 : col_inc[dlir_pkg::COL_W-1:0];
        phase_add = phase_reg + {1'b0, step_reg};
        pt_last   = (phase_add >= dlir_pkg::PHASE_ONE) || (cnt_reg == dlir_pkg::CNT_LAST);
        phase_fin = (phase_reg < dlir_pkg::PHASE_ONE) ? '0
                                                      : phase_reg - dlir_pkg::PHASE_ONE;
    end

    // The blend is rewritten as prev * 2^16 + (cur - prev) * frac.
    always_comb
    begin
        diff        = $signed({cur_reg[dlir_pkg::SAMPLE_W-1], cur_reg})
                    - $signed({prev_reg[dlir_pkg::SAMPLE_W-1], prev_reg});
        diff_prod   = dlir_pkg::BLEND_W'(diff)
                    * dlir_pkg::BLEND_W'($signed({1'b0, frac_reg}));
        prev_scaled = $signed({{2{prev_reg[dlir_pkg::SAMPLE_W-1]}}, prev_reg,
                               {dlir_pkg::FRAC_W{1'b0}}});
        blend_sum   = prev_scaled + diff_prod;
        gain_prod   = dlir_pkg::PROD_W'(blend_reg)
                    * dlir_pkg::PROD_W'($signed({1'b0, gain_reg}));
    end

    // Round half up, then saturate to the 24-bit point range.
    always_comb
    begin
        rounded = prod_reg + (dlir_pkg::PROD_W'(1) <<< (dlir_pkg::ROUND_SHIFT - 1));
        quot    = rounded >>> dlir_pkg::ROUND_SHIFT;
        ovf     = (quot[dlir_pkg::PROD_W-1:dlir_pkg::POINT_W-1]
                   != {(dlir_pkg::PROD_W - dlir_pkg::POINT_W + 1){quot[dlir_pkg::PROD_W-1]}});
        if (ovf)
        begin
            pt_sat = quot[dlir_pkg::PROD_W-1] ? dlir_pkg::PT_MIN : dlir_pkg::PT_MAX;
        end
        else
        begin
            pt_sat = quot[dlir_pkg::POINT_W-1:0];
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= dlir_pkg::STEP_RESET;
            gain_reg      <= dlir_pkg::GAIN_RESET;
            width_reg     <= dlir_pkg::WIDTH_RESET;
            prev_reg      <= '0;
            primed_reg    <= 1'b0;
            phase_reg     <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    dlir_pkg::CFG_PHASE_STEP:   step_reg  <= cfg_wdata;
                    dlir_pkg::CFG_GAIN:         gain_reg  <= cfg_wdata[dlir_pkg::GAIN_W-1:0];
                    dlir_pkg::CFG_SCREEN_WIDTH: width_reg <= cfg_wdata[dlir_pkg::WIDTH_W-1:0];
                    default:                    ;
                endcase
            end
            if (cmd.accept)
            begin
                cnt_reg <= '0;
                if (in_restart)
                begin
                    col_reg    <= '0;
                    phase_reg  <= '0;
                    prev_reg   <= in_sample;
                    primed_reg <= 1'b1;
                end
                else if (!primed_reg)
                begin
                    prev_reg   <= in_sample;
                    primed_reg <= 1'b1;
                end
            end
            if (cmd.point)
            begin
                phase_reg <= phase_add;
                col_reg   <= col_nxt;
                cnt_reg   <= cnt_reg + dlir_pkg::CNT_W'(1);
            end
            if (cmd.finish)
            begin
                phase_reg <= phase_fin;
                prev_reg  <= cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_reg <= in_sample;
        end
        if (cmd.point)
        begin
            frac_reg  <= phase_reg[dlir_pkg::FRAC_W-1:0];
            pcol_reg  <= col_eff;
            plast_reg <= pt_last;
        end
        if (cmd.mul1)
        begin
            blend_reg <= blend_sum;
        end
        if (cmd.mul2)
        begin
            prod_reg <= gain_prod;
        end
        if (cmd.emit)
        begin
            out_col_reg  <= pcol_reg;
            out_pt_reg   <= pt_sat;
            out_last_reg <= plast_reg;
        end
    end

    assign status.primed   = primed_reg;
    assign status.point_go = (phase_reg < dlir_pkg::PHASE_ONE) && (cnt_reg < dlir_pkg::CNT_MAX);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_column = out_col_reg;
    assign out_point  = out_pt_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/display_linear_interp_resampler.sv -----
// After a sample's beat, its first point goes through the point set-up, the two multiply
// steps and the output load of the controller in turn, each registered; the output load
// stalls while the output register still holds an untaken point. A sample's points go
// through that loop one after another; a restart or priming sample gives no point.
// One sample is worked on at a time; a finished point waits in the output register.
// Reset (rst_n, asynchronous, active low) clears phase, column, previous sample
// and primed state and loads phase_step 1.0, gain 1.0 and screen_width 1024.
`timescale 1ns / 1ps
`default_nettype none

module display_linear_interp_resampler
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dlir_pkg::SAMPLE_W-1:0]   s_tdata,  // sample
    input  wire logic [0:0]                      s_tuser,  // restart
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dlir_pkg::OUT_TDATA_W-1:0]     m_tdata,  // column, point_value, zero pad
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dlir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dlir_pkg::CFG_DATA_W-1:0] cfg_data
);

    dlir_pkg::cmd_t    cmd;
    dlir_pkg::status_t status;

    logic [dlir_pkg::COL_W-1:0]   out_column;
    logic [dlir_pkg::POINT_W-1:0] out_point;

    assign cfg_ready = 1'b1;

    dlir_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_restart (s_tuser[0]),
        .in_ready   (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    dlir_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .in_sample  (s_tdata),
        .in_restart (s_tuser[0]),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_column (out_column),
        .out_point  (out_point),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(dlir_pkg::OUT_TDATA_W - dlir_pkg::COL_W - dlir_pkg::POINT_W){1'b0}},
                      out_point, out_column};

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("Output register loaded while it still held an untaken point.");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0] && status.primed) |=> !s_tready)
        else $error("Input ready stayed high while a sample was being worked on.");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("Output beat appeared without a load from the controller.");

endmodule

`default_nettype wire
